// ===== src/q4k_pkg.sv =====
package q4k_pkg;

  localparam int WGT_WORDS = 288;
  localparam int ACT_WORDS = 292;
  localparam int SCL_WORDS = 32;
  localparam int TILE_N    = 32;
  localparam int DOT_STEPS = 16;
  localparam int MIN_STEPS = 8;

  localparam logic [31:0] KMASK_SIX = 32'h3f3f3f3f;
  localparam logic [31:0] KMASK_LOW = 32'h0f0f0f0f;
  localparam logic [31:0] KMASK_TWO = 32'h03030303;
  localparam logic [31:0] FP_QNAN   = 32'hffc00000;
  localparam logic [31:0] FP_QUIET  = 32'h00400000;

  typedef enum logic [1:0] {
    OP_LOAD_WGT = 2'd0,
    OP_LOAD_ACT = 2'd1,
    OP_ACCUM    = 2'd2,
    OP_EMIT     = 2'd3
  } op_t;

  // unrounded fp32 intermediate: sig has its top bit at 47 for biased exponent exp_b
  typedef struct packed {
    logic               spec;
    logic [31:0]        spec_val;
    logic               sign;
    logic signed [10:0] exp_b;
    logic [47:0]        sig;
  } fpx_t;

  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic [4:0]  ex;
    logic [9:0]  man;
    logic [9:0]  m;
    logic [31:0] r;
    int          p;
    ex  = h[14:10];
    man = h[9:0];
    p   = 0;
    for (int i = 0; i < 10; i++) begin
      if (man[i]) p = i;
    end
    m = 10'(man << (10 - p));
    if (ex == 5'h1f) begin
      r = {h[15], 8'hff, man, 13'd0};
    end else if (ex != 5'd0) begin
      r = {h[15], {3'b000, ex} + 8'd112, man, 13'd0};
    end else if (man == 10'd0) begin
      r = {h[15], 31'd0};
    end else begin
      r = {h[15], 8'(103 + p), m, 13'd0};
    end
    return r;
  endfunction

  // exact for magnitudes below 2^24
  function automatic logic [31:0] int_to_single(input logic signed [23:0] v);
    logic [23:0] mag;
    logic [23:0] n;
    logic [31:0] r;
    int          p;
    mag = v[23] ? 24'(-v) : 24'(v);
    p   = 0;
    for (int i = 0; i < 24; i++) begin
      if (mag[i]) p = i;
    end
    n = 24'(mag << (23 - p));
    if (mag == 24'd0) r = 32'd0;
    else r = {v[23], 8'(127 + p), n[22:0]};
    return r;
  endfunction

  function automatic fpx_t mul_pre(input logic [31:0] a, input logic [31:0] b);
    fpx_t        x;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [23:0] ma, mb;
    logic [7:0]  ea, eb;
    a_nan  = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
    b_nan  = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
    a_inf  = (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
    b_inf  = (b[30:23] == 8'hff) && (b[22:0] == 23'd0);
    a_zero = (a[30:0] == 31'd0);
    b_zero = (b[30:0] == 31'd0);
    ma = {a[30:23] != 8'd0, a[22:0]};
    mb = {b[30:23] != 8'd0, b[22:0]};
    ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    x = '0;
    x.sign  = a[31] ^ b[31];
    x.exp_b = $signed({3'b000, ea}) + $signed({3'b000, eb}) - 11'sd126;
    x.sig   = {24'd0, ma} * {24'd0, mb};
    if (a_nan) begin
      x.spec = 1'b1; x.spec_val = a | FP_QUIET;
    end else if (b_nan) begin
      x.spec = 1'b1; x.spec_val = b | FP_QUIET;
    end else if ((a_inf && b_zero) || (b_inf && a_zero)) begin
      x.spec = 1'b1; x.spec_val = FP_QNAN;
    end else if (a_inf || b_inf) begin
      x.spec = 1'b1; x.spec_val = {x.sign, 8'hff, 23'd0};
    end else if (a_zero || b_zero) begin
      x.spec = 1'b1; x.spec_val = {x.sign, 31'd0};
    end
    return x;
  endfunction

  function automatic fpx_t add_pre(input logic [31:0] a, input logic [31:0] b,
                                   input logic sub);
    fpx_t        x;
    logic        bs, a_nan, b_nan, a_inf, b_inf, a_big, s_l, s_s, st;
    logic [23:0] ma, mb, m_l, m_s;
    logic [7:0]  ea, eb, e_l, e_s, d;
    logic [47:0] sig_l, sig_s0, sig_s, sum;
    bs    = b[31] ^ sub;
    a_nan = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
    b_nan = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
    a_inf = (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
    b_inf = (b[30:23] == 8'hff) && (b[22:0] == 23'd0);
    ma = {a[30:23] != 8'd0, a[22:0]};
    mb = {b[30:23] != 8'd0, b[22:0]};
    ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    a_big = {ea, ma} >= {eb, mb};
    e_l = a_big ? ea : eb;
    e_s = a_big ? eb : ea;
    m_l = a_big ? ma : mb;
    m_s = a_big ? mb : ma;
    s_l = a_big ? a[31] : bs;
    s_s = a_big ? bs : a[31];
    d   = e_l - e_s;
    sig_l  = {1'b0, m_l, 23'd0};
    sig_s0 = {1'b0, m_s, 23'd0};
    st     = |(sig_s0 & ~(48'hffff_ffff_ffff << d));
    sig_s  = (sig_s0 >> d) | {47'd0, st};
    sum    = (s_l == s_s) ? sig_l + sig_s : sig_l - sig_s;
    x = '0;
    x.sign  = (sum == 48'd0) ? (s_l & s_s) : s_l;
    x.exp_b = $signed({3'b000, e_l}) + 11'sd1;
    x.sig   = sum;
    if (a_nan) begin
      x.spec = 1'b1; x.spec_val = a | FP_QUIET;
    end else if (b_nan) begin
      x.spec = 1'b1; x.spec_val = b | FP_QUIET;
    end else if (a_inf && b_inf && (a[31] != bs)) begin
      x.spec = 1'b1; x.spec_val = FP_QNAN;
    end else if (a_inf) begin
      x.spec = 1'b1; x.spec_val = a;
    end else if (b_inf) begin
      x.spec = 1'b1; x.spec_val = {bs, b[30:0]};
    end
    return x;
  endfunction

  // normalise, denormalise and round to nearest even
  function automatic logic [31:0] fp_round(input fpx_t x);
    logic [47:0]        n;
    logic signed [11:0] e;
    logic               st, g, rnd;
    logic [22:0]        m;
    logic [30:0]        mag;
    logic [31:0]        r;
    int                 p;
    int                 sh;
    p = 0;
    for (int i = 0; i < 48; i++) begin
      if (x.sig[i]) p = i;
    end
    n  = 48'(x.sig << (47 - p));
    e  = $signed({x.exp_b[10], x.exp_b}) - $signed(12'(47 - p));
    st = 1'b0;
    if (e < 12'sd1) begin
      sh = 1 - e;
      st = |(n & ~(48'hffff_ffff_ffff << sh));
      n  = n >> sh;
      e  = 12'sd0;
    end
    m   = n[46:24];
    g   = n[23];
    st  = st | (|n[22:0]);
    rnd = g & (st | m[0]);
    mag = {e[7:0], m} + 31'(rnd);
    if (x.spec) r = x.spec_val;
    else if (x.sig == 48'd0) r = {x.sign, 31'd0};
    else if (e >= 12'sd255) r = {x.sign, 8'hff, 23'd0};
    else r = {x.sign, mag};
    return r;
  endfunction

endpackage

// ===== src/q4k_cmd_if.sv =====
interface q4k_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [8:0]  word_index;
  logic [31:0] word;

  modport source (output valid, operation, word_index, word, input ready);
  modport sink (input valid, operation, word_index, word, output ready);
endinterface

// ===== src/q4k_res_if.sv =====
interface q4k_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_row;
  logic [2:0]  out_col;
  logic [31:0] value;
  logic        last;

  modport source (output valid, out_row, out_col, value, last, input ready);
  modport sink (input valid, out_row, out_col, value, last, output ready);
endinterface

// ===== src/q4k_ram.sv =====
module q4k_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end
endmodule

// ===== src/q4k_q8k_tile_dot_product_core.sv =====
// Q4_K x Q8_K tile core. Accumulates one 4x8 output tile of a product of Q4_K weights
// (interleaved over 8 columns) and Q8_K activations (interleaved over 4 rows). Requests
// on cmd: operation 0 stores a 32-bit word of the weight superblock (index 0..287),
// operation 1 a word of the activation superblock (index 0..291); out-of-range indexes
// are dropped, and a load leaves the core idle. Operation 2 unpacks the 6-bit scales/mins
// into a 32-word table and then folds the whole superblock into the fp32 dot and min
// accumulators, one output at a time: per output sixteen dot steps and eight min
// steps, serialised by the single read port of each store and by one shared fp32
// multiplier and adder that each step's terms pass through in
// a serial chain (int->float, x scale, x row scale, + accumulator). Operation 3 sends
// 32 results, row-major, each the dot sum minus the min sum, with last on row 3
// column 7, each registered as soon as the output register frees; the accumulators are
// cleared as they are read. cmd is held off while an accumulate or emit runs; a
// finished result waits in the output register without blocking load requests.
// Words must be loaded before an accumulate reads them.
module q4k_q8k_tile_dot_product_core (
  input logic       clk,
  input logic       rst,
  q4k_cmd_if.sink   cmd,
  q4k_res_if.source res
);
  import q4k_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_UNPK, S_HEAD, S_FETCH, S_SUMS, S_PROD, S_CONV,
    S_MULB, S_RNDB, S_MULA, S_RNDA, S_ADD, S_RNDC, S_WB,
    S_EMIT_RD, S_EMIT_SUB, S_EMIT_OUT
  } state_t;

  state_t state;

  // sequencing counters
  logic [4:0] o;       // output index, row in [4:3], column in [2:0]
  logic [3:0] k;       // dot step 0..15, or min group 0..7
  logic [2:0] fc;      // fetch phase
  logic [2:0] uc;      // unpack phase
  logic [2:0] sb_u;    // unpack group
  logic       mphase;  // 0 dot terms, 1 min terms
  logic [TILE_N-1:0] acc_vld;

  // datapath
  logic [31:0] u0, u1, u2;
  logic [31:0] da, db, dbm, acc, macc;
  logic [31:0] wd0, wd1, ad0, ad1, ad2, ad3;
  logic [5:0]  sc0, sc1;
  logic signed [16:0] s0, s1;
  logic signed [23:0] sumi;
  logic [31:0] fa, fr;
  fpx_t        fx;

  logic        res_valid, res_last;
  logic [1:0]  res_row;
  logic [2:0]  res_col;
  logic [31:0] res_value;

  logic [1:0] y;
  logic [2:0] c;
  assign y = o[4:3];
  assign c = o[2:0];

  logic cmd_fire;
  assign cmd.ready = (state == S_IDLE);
  assign cmd_fire  = cmd.valid && cmd.ready;

  // memories
  logic        w_we, a_we, s_we, m_we;
  logic [8:0]  w_rd_addr, a_rd_addr;
  logic [4:0]  s_rd_addr, s_wr_addr;
  logic [31:0] w_rd_data, a_rd_data, s_rd_data, s_wr_data;
  logic [63:0] m_rd_data;

  assign w_we = cmd_fire && (cmd.operation == OP_LOAD_WGT) &&
                (cmd.word_index < 9'(WGT_WORDS));
  assign a_we = cmd_fire && (cmd.operation == OP_LOAD_ACT) &&
                (cmd.word_index < 9'(ACT_WORDS));
  assign m_we = (state == S_WB);

  q4k_ram #(.WIDTH(32), .DEPTH(WGT_WORDS)) u_wgt (
    .clk, .wr_en(w_we), .wr_addr(cmd.word_index), .wr_data(cmd.word),
    .rd_addr(w_rd_addr), .rd_data(w_rd_data)
  );

  q4k_ram #(.WIDTH(32), .DEPTH(ACT_WORDS)) u_act (
    .clk, .wr_en(a_we), .wr_addr(cmd.word_index), .wr_data(cmd.word),
    .rd_addr(a_rd_addr), .rd_data(a_rd_data)
  );

  q4k_ram #(.WIDTH(32), .DEPTH(SCL_WORDS)) u_scl (
    .clk, .wr_en(s_we), .wr_addr(s_wr_addr), .wr_data(s_wr_data),
    .rd_addr(s_rd_addr), .rd_data(s_rd_data)
  );

  // dot sum in [63:32], min sum in [31:0]; entries not valid read as +0.0
  q4k_ram #(.WIDTH(64), .DEPTH(TILE_N)) u_accm (
    .clk, .wr_en(m_we), .wr_addr(o), .wr_data({acc, macc}),
    .rd_addr(o), .rd_data(m_rd_data)
  );

  // scale table write: kmask unpack of one 12-byte group into four words
  assign s_we      = (state == S_UNPK) && (uc >= 3'd3);
  assign s_wr_addr = {sb_u, 2'(uc - 3'd3)};
  always_comb begin
    case (uc)
      3'd3:    s_wr_data = u0 & KMASK_SIX;
      3'd4:    s_wr_data = (u2 & KMASK_LOW) | (((u0 >> 6) & KMASK_TWO) << 4);
      3'd5:    s_wr_data = u1 & KMASK_SIX;
      3'd6:    s_wr_data = ((u2 >> 4) & KMASK_LOW) | (((u1 >> 6) & KMASK_TWO) << 4);
      default: s_wr_data = '0;
    endcase
  end

  // min group: pair of int16 sums, always in one word
  logic [6:0] bi;
  assign bi = {1'b0, k[2:0], 3'b000} + {3'b000, y, 2'b00} - (k[0] ? 7'd6 : 7'd0);

  logic [8:0] a_dot_base;
  assign a_dot_base = 9'd4 + {1'b0, k[3:2], 1'b0, k[1:0], y, 1'b0};

  // read addresses
  always_comb begin
    w_rd_addr = '0;
    a_rd_addr = '0;
    s_rd_addr = '0;
    case (state)
      S_UNPK: begin
        w_rd_addr = 9'(8 + 3 * int'(sb_u) + int'(uc));
      end
      S_HEAD: begin
        a_rd_addr = {7'd0, y};
        w_rd_addr = (fc == 3'd0) ? {7'd0, c[2:1]} : 9'd4 + {7'd0, c[2:1]};
      end
      S_FETCH: begin
        if (!mphase) begin
          w_rd_addr = 9'd32 + {1'b0, k, c, fc[0]};
          case (fc)
            3'd0:    a_rd_addr = a_dot_base;
            3'd1:    a_rd_addr = a_dot_base + 9'd1;
            3'd2:    a_rd_addr = a_dot_base + 9'd32;
            default: a_rd_addr = a_dot_base + 9'd33;
          endcase
          s_rd_addr = {k[3:2], fc[0], 1'b0, c[2]};
        end else begin
          a_rd_addr = 9'd260 + 9'(bi[5:1]);
          s_rd_addr = {k[2:0], 1'b1, c[2]};
        end
      end
      default: ;
    endcase
  end

  logic [5:0] s_byte;
  assign s_byte = s_rd_data[{c[1:0], 3'b000} +: 6];

  // nibble x int8 sums over eight bytes
  logic signed [16:0] dot_lo, dot_hi, sum16;
  always_comb begin
    logic signed [12:0] pl, ph;
    logic [63:0] wq, alo, ahi;
    wq  = {wd1, wd0};
    alo = {ad1, ad0};
    ahi = {ad3, ad2};
    dot_lo = '0;
    dot_hi = '0;
    for (int j = 0; j < 8; j++) begin
      pl = $signed({1'b0, wq[8*j +: 4]}) * $signed(alo[8*j +: 8]);
      ph = $signed({1'b0, wq[8*j+4 +: 4]}) * $signed(ahi[8*j +: 8]);
      dot_lo = dot_lo + pl;
      dot_hi = dot_hi + ph;
    end
  end
  assign sum16 = $signed(ad0[15:0]) + $signed(ad0[31:16]);

  logic signed [23:0] p_lo, p_hi;
  assign p_lo = s0 * $signed({1'b0, sc0});
  assign p_hi = s1 * $signed({1'b0, sc1});

  // shared fp32 unit: one multiplier front end, one adder front end, one rounder
  logic [31:0] mul_a, mul_b, add_a, add_b, dot_val, min_val, rnd_val;
  logic        add_sub;
  fpx_t        pre_mul, pre_add;

  assign dot_val = acc_vld[o] ? m_rd_data[63:32] : 32'd0;
  assign min_val = acc_vld[o] ? m_rd_data[31:0]  : 32'd0;
  assign mul_a   = (state == S_MULB) ? fa : fr;
  assign mul_b   = (state == S_MULB) ? (mphase ? dbm : db) : da;
  assign add_a   = (state == S_EMIT_SUB) ? dot_val : (mphase ? macc : acc);
  assign add_b   = (state == S_EMIT_SUB) ? min_val : fr;
  assign add_sub = (state == S_EMIT_SUB);
  assign pre_mul = mul_pre(mul_a, mul_b);
  assign pre_add = add_pre(add_a, add_b, add_sub);
  assign rnd_val = fp_round(fx);

  logic emit_load;
  assign emit_load = (state == S_EMIT_OUT) && (!res_valid || res.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      o         <= '0;
      k         <= '0;
      fc        <= '0;
      uc        <= '0;
      sb_u      <= '0;
      mphase    <= 1'b0;
      acc_vld   <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res.ready && !emit_load) res_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cmd_fire) begin
            case (cmd.operation)
              OP_ACCUM: begin
                state <= S_UNPK;
                uc    <= '0;
                sb_u  <= '0;
              end
              OP_EMIT: begin
                state <= S_EMIT_RD;
                o     <= '0;
              end
              default: ;
            endcase
          end
        end
        S_UNPK: begin
          case (uc)
            3'd1:    u0 <= w_rd_data;
            3'd2:    u1 <= w_rd_data;
            3'd3:    u2 <= w_rd_data;
            default: ;
          endcase
          if (uc == 3'd6) begin
            uc <= '0;
            if (sb_u == 3'd7) begin
              state <= S_HEAD;
              o     <= '0;
              fc    <= '0;
            end else begin
              sb_u <= sb_u + 3'd1;
            end
          end else begin
            uc <= uc + 3'd1;
          end
        end
        S_HEAD: begin
          if (fc == 3'd1) begin
            da   <= a_rd_data;
            db   <= half_to_single(c[0] ? w_rd_data[31:16] : w_rd_data[15:0]);
            acc  <= dot_val;
            macc <= min_val;
          end
          if (fc == 3'd2) begin
            dbm    <= half_to_single(c[0] ? w_rd_data[31:16] : w_rd_data[15:0]);
            state  <= S_FETCH;
            fc     <= '0;
            k      <= '0;
            mphase <= 1'b0;
          end else begin
            fc <= fc + 3'd1;
          end
        end
        S_FETCH: begin
          fc <= fc + 3'd1;
          if (!mphase) begin
            case (fc)
              3'd1: begin
                wd0 <= w_rd_data; ad0 <= a_rd_data; sc0 <= s_byte;
              end
              3'd2: begin
                wd1 <= w_rd_data; ad1 <= a_rd_data; sc1 <= s_byte;
              end
              3'd3:    ad2 <= a_rd_data;
              3'd4: begin
                ad3   <= a_rd_data;
                state <= S_SUMS;
              end
              default: ;
            endcase
          end else if (fc == 3'd1) begin
            ad0   <= a_rd_data;
            sc0   <= s_byte;
            state <= S_SUMS;
          end
        end
        S_SUMS: begin
          s0    <= mphase ? sum16 : dot_lo;
          s1    <= dot_hi;
          state <= S_PROD;
        end
        S_PROD: begin
          sumi  <= mphase ? p_lo : p_lo + p_hi;
          state <= S_CONV;
        end
        S_CONV: begin
          fa    <= int_to_single(sumi);
          state <= S_MULB;
        end
        S_MULB: begin
          fx    <= pre_mul;
          state <= S_RNDB;
        end
        S_RNDB: begin
          fr    <= rnd_val;
          state <= S_MULA;
        end
        S_MULA: begin
          fx    <= pre_mul;
          state <= S_RNDA;
        end
        S_RNDA: begin
          fr    <= rnd_val;
          state <= S_ADD;
        end
        S_ADD: begin
          fx    <= pre_add;
          state <= S_RNDC;
        end
        S_RNDC: begin
          fc <= '0;
          if (!mphase) begin
            acc   <= rnd_val;
            state <= S_FETCH;
            if (k == 4'(DOT_STEPS - 1)) begin
              mphase <= 1'b1;
              k      <= '0;
            end else begin
              k <= k + 4'd1;
            end
          end else begin
            macc <= rnd_val;
            if (k == 4'(MIN_STEPS - 1)) begin
              state <= S_WB;
            end else begin
              k     <= k + 4'd1;
              state <= S_FETCH;
            end
          end
        end
        S_WB: begin
          acc_vld[o] <= 1'b1;
          fc         <= '0;
          if (o == 5'(TILE_N - 1)) begin
            state <= S_IDLE;
          end else begin
            o     <= o + 5'd1;
            state <= S_HEAD;
          end
        end
        S_EMIT_RD: begin
          state <= S_EMIT_SUB;
        end
        S_EMIT_SUB: begin
          fx    <= pre_add;
          state <= S_EMIT_OUT;
        end
        S_EMIT_OUT: begin
          if (emit_load) begin
            res_valid  <= 1'b1;
            res_row    <= y;
            res_col    <= c;
            res_value  <= rnd_val;
            res_last   <= (o == 5'(TILE_N - 1));
            acc_vld[o] <= 1'b0;
            if (o == 5'(TILE_N - 1)) begin
              state <= S_IDLE;
            end else begin
              o     <= o + 5'd1;
              state <= S_EMIT_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign res.valid   = res_valid;
  assign res.out_row = res_row;
  assign res.out_col = res_col;
  assign res.value   = res_value;
  assign res.last    = res_last;

`ifndef SYNTHESIS
  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_last) |-> (res_row == 2'd3 && res_col == 3'd7))
    else $error("last flag away from final tile position");

  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    (emit_load && o == 5'(TILE_N - 1)) |=> (acc_vld == '0))
    else $error("accumulators not cleared after emit");

  a_min_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_FETCH && mphase) |-> (k <= 4'(MIN_STEPS - 1)))
    else $error("min group counter out of range");

  a_accum_start: assert property (@(posedge clk) disable iff (rst)
    (cmd_fire && cmd.operation == OP_ACCUM) |=> (state == S_UNPK && sb_u == 3'd0))
    else $error("accumulate did not start with scale unpack");
`endif
endmodule

// ===== tb/q4k_q8k_tile_dot_product_core_test.sv =====
`timescale 1ns / 1ps

// Tile model: mirrors the core's stores and fp32 accumulators and holds
// the results that emit requests still owe.
class q4k_tile_model;

  typedef struct {
    logic [1:0]  row;
    logic [2:0]  col;
    logic [31:0] value;
    logic        last;
  } tile_result_t;

  logic [31:0]  wgt[q4k_pkg::WGT_WORDS];
  logic [31:0]  act[q4k_pkg::ACT_WORDS];
  logic [31:0]  scl[q4k_pkg::SCL_WORDS];
  logic [31:0]  dot_acc[q4k_pkg::TILE_N];
  logic [31:0]  min_acc[q4k_pkg::TILE_N];
  tile_result_t owed[$];
  int           mismatches;

  function new();
    foreach (wgt[i]) wgt[i] = '0;
    foreach (act[i]) act[i] = '0;
    foreach (scl[i]) scl[i] = '0;
    foreach (dot_acc[i]) begin
      dot_acc[i] = '0;
      min_acc[i] = '0;
    end
    mismatches = 0;
  endfunction

  // round sig * 2^e2 to fp32, nearest even, with subnormals and overflow
  function logic [31:0] round_fp(logic s, logic [63:0] sig, int e2);
    int           p, q, sh, ex;
    logic [127:0] ext;
    logic [63:0]  m;
    logic         g, st;
    p = 0;
    for (int i = 0; i < 64; i++) if (sig[i]) p = i;
    q = p + e2 - 23;
    if (q < -149) q = -149;
    sh = q - e2;
    g = 1'b0;
    st = 1'b0;
    if (sig == 64'd0) return {s, 31'd0};
    if (sh <= 0) begin
      m = sig << (-sh);
    end else if (sh >= 128) begin
      m = '0;
      st = 1'b1;
    end else begin
      ext = {sig, 64'd0} >> sh;
      m = ext[127:64];
      g = ext[63];
      st = |ext[62:0];
    end
    if (g && (st || m[0])) m = m + 64'd1;
    if (m == 64'h100_0000) begin
      m = m >> 1;
      q = q + 1;
    end
    ex = m[23] ? q + 150 : 0;
    if (ex >= 255) return {s, 8'hff, 23'd0};
    return {s, ex[7:0], m[22:0]};
  endfunction

  function logic is_nan(logic [31:0] a);
    return a[30:23] == 8'hff && a[22:0] != 0;
  endfunction

  function logic is_inf(logic [31:0] a);
    return a[30:23] == 8'hff && a[22:0] == 0;
  endfunction

  function logic [31:0] fmul(logic [31:0] a, logic [31:0] b);
    logic        s;
    logic [23:0] ma, mb;
    int          ea, eb;
    s = a[31] ^ b[31];
    if (is_nan(a)) return a | 32'h0040_0000;
    if (is_nan(b)) return b | 32'h0040_0000;
    if ((is_inf(a) && b[30:0] == 0) || (is_inf(b) && a[30:0] == 0)) return 32'hffc0_0000;
    if (is_inf(a) || is_inf(b)) return {s, 8'hff, 23'd0};
    if (a[30:0] == 0 || b[30:0] == 0) return {s, 31'd0};
    ma = {a[30:23] != 0, a[22:0]};
    mb = {b[30:23] != 0, b[22:0]};
    ea = a[30:23] == 0 ? 1 : int'(a[30:23]);
    eb = b[30:23] == 0 ? 1 : int'(b[30:23]);
    return round_fp(s, 64'(ma) * 64'(mb), ea + eb - 300);
  endfunction

  // a + b, or a - b when neg is set
  function logic [31:0] fadd(logic [31:0] a, logic [31:0] b, logic neg);
    logic        sb, sl, ss;
    logic [23:0] ma, mb, ml, ms;
    int          ea, eb, el, d;
    logic [63:0] big, sml, ext, sum;
    sb = b[31] ^ neg;
    if (is_nan(a)) return a | 32'h0040_0000;
    if (is_nan(b)) return b | 32'h0040_0000;
    if (is_inf(a) && is_inf(b) && a[31] != sb) return 32'hffc0_0000;
    if (is_inf(a)) return a;
    if (is_inf(b)) return {sb, b[30:0]};
    ma = {a[30:23] != 0, a[22:0]};
    mb = {b[30:23] != 0, b[22:0]};
    ea = a[30:23] == 0 ? 1 : int'(a[30:23]);
    eb = b[30:23] == 0 ? 1 : int'(b[30:23]);
    if ({ea[7:0], ma} >= {eb[7:0], mb}) begin
      el = ea; ml = ma; sl = a[31]; ms = mb; ss = sb; d = ea - eb;
    end else begin
      el = eb; ml = mb; sl = sb; ms = ma; ss = a[31]; d = eb - ea;
    end
    big = 64'(ml) << 39;
    ext = 64'(ms) << 39;
    if (d >= 64) sml = {63'd0, ms != 0};
    else sml = (ext >> d) | {63'd0, (ext & ((64'd1 << d) - 64'd1)) != 0};
    sum = (sl == ss) ? big + sml : big - sml;
    if (sum == 64'd0) return {sl & ss, 31'd0};
    return round_fp(sl, sum, el - 189);
  endfunction

  function logic [31:0] half_fp(logic [15:0] h);
    if (h[14:10] == 5'h1f) return {h[15], 8'hff, h[9:0], 13'd0};
    if (h[14:10] != 0) return {h[15], 8'(h[14:10]) + 8'd112, h[9:0], 13'd0};
    return round_fp(h[15], 64'(h[9:0]), -24);
  endfunction

  function logic [31:0] int_fp(int v);
    return round_fp(v < 0, 64'(v < 0 ? -v : v), 0);
  endfunction

  function logic [7:0] wb(int b);
    return 8'(wgt[b >> 2] >> ((b & 3) * 8));
  endfunction

  function logic [7:0] ab(int b);
    return 8'(act[b >> 2] >> ((b & 3) * 8));
  endfunction

  function int sb(int b);
    return int'(8'(scl[(b >> 2) & 31] >> ((b & 3) * 8)));
  endfunction

  function int group_sum(int i);
    return int'(signed'({ab(1041 + 2 * i), ab(1040 + 2 * i)}));
  endfunction

  // kmask unpack, then one pass over the superblock for every output
  function void fold_superblock();
    logic [31:0] s0, s1, s2, da, db, dbm, acc, macc, t;
    int          o, ib, ia, sc0, sc1, p0, p1, bi, m;
    logic [7:0]  q;
    for (int g = 0; g < 8; g++) begin
      s0 = wgt[8 + g * 3];
      s1 = wgt[9 + g * 3];
      s2 = wgt[10 + g * 3];
      scl[g * 4]     = s0 & q4k_pkg::KMASK_SIX;
      scl[g * 4 + 1] = (s2 & q4k_pkg::KMASK_LOW) | (((s0 >> 6) & q4k_pkg::KMASK_TWO) << 4);
      scl[g * 4 + 2] = s1 & q4k_pkg::KMASK_SIX;
      scl[g * 4 + 3] = ((s2 >> 4) & q4k_pkg::KMASK_LOW) |
                       (((s1 >> 6) & q4k_pkg::KMASK_TWO) << 4);
    end
    for (int y = 0; y < 4; y++) begin
      da = act[y];
      for (int c = 0; c < 8; c++) begin
        o = y * 8 + c;
        db = half_fp({wb(2 * c + 1), wb(2 * c)});
        dbm = half_fp({wb(17 + 2 * c), wb(16 + 2 * c)});
        acc = dot_acc[o];
        macc = min_acc[o];
        for (int k = 0; k < q4k_pkg::DOT_STEPS; k++) begin
          ib = k * 64 + c * 8;
          ia = (k >> 2) * 256 + (k & 3) * 32 + y * 8;
          sc0 = sb((k >> 2) * 32 + c);
          sc1 = sb((k >> 2) * 32 + 16 + c);
          p0 = 0;
          p1 = 0;
          for (int j = 0; j < 8; j++) begin
            q = wb(128 + ib + j);
            p0 += int'(q[3:0]) * int'(signed'(ab(16 + ia + j)));
            p1 += int'(q[7:4]) * int'(signed'(ab(144 + ia + j)));
          end
          t = fmul(fmul(int_fp(p0 * sc0 + p1 * sc1), db), da);
          acc = fadd(acc, t, 1'b0);
        end
        for (int g = 0; g < q4k_pkg::MIN_STEPS; g++) begin
          bi = g * 8 + y * 4 - (g & 1) * 6;
          m = sb(8 + g * 16 + c) * (group_sum(bi & 63) + group_sum((bi + 1) & 63));
          t = fmul(fmul(int_fp(m), dbm), da);
          macc = fadd(macc, t, 1'b0);
        end
        dot_acc[o] = acc;
        min_acc[o] = macc;
      end
    end
  endfunction

  function void take_request(q4k_pkg::op_t op, logic [8:0] idx, logic [31:0] w);
    tile_result_t r;
    case (op)
      q4k_pkg::OP_LOAD_WGT: if (idx < q4k_pkg::WGT_WORDS) wgt[idx] = w;
      q4k_pkg::OP_LOAD_ACT: if (idx < q4k_pkg::ACT_WORDS) act[idx] = w;
      q4k_pkg::OP_ACCUM: fold_superblock();
      default: begin
        for (int o = 0; o < q4k_pkg::TILE_N; o++) begin
          r.row = 2'(o / 8);
          r.col = 3'(o % 8);
          r.value = fadd(dot_acc[o], min_acc[o], 1'b1);
          r.last = (o == q4k_pkg::TILE_N - 1);
          owed.push_back(r);
          dot_acc[o] = '0;
          min_acc[o] = '0;
        end
      end
    endcase
  endfunction

  function void check_result(logic [1:0] row, logic [2:0] col, logic [31:0] value,
                             logic last);
    tile_result_t e;
    if (owed.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result row %0d col %0d value %h", row, col,
                                     value);
      return;
    end
    e = owed.pop_front();
    if (row !== e.row || col !== e.col || value !== e.value || last !== e.last) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result mismatch: exp r%0d c%0d %h l%0d, got r%0d c%0d %h l%0d",
                 e.row, e.col, e.value, e.last, row, col, value, last);
    end
  endfunction

endclass

module q4k_q8k_tile_dot_product_core_test;
  import q4k_pkg::*;

  localparam int LIMIT = 1_000_000;

  logic clk;
  logic rst;
  int   cycles = 0;
  logic calm;       // no idling on either side while set
  int   hold_left;  // receiver hold-off, counted down per cycle
  int   hold_req;
  logic hold_done;

  q4k_cmd_if     cmd ();
  q4k_res_if     res ();
  q4k_tile_model tile;

  q4k_q8k_tile_dot_product_core dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .res (res)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Run limit: report an error and stop once the cycle count passes LIMIT.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result side: random back-pressure, plus one long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_req != 0 && !hold_done) begin
      hold_left <= hold_req;
      hold_done <= 1'b1;
      res.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      res.ready <= 1'b0;
    end else begin
      res.ready <= calm || ($urandom_range(99) >= 34);
    end
  end

  // Results are sampled at the edge, before this step's updates land.
  always @(posedge clk) begin
    if (!rst && res.valid && res.ready) tile.check_result(res.out_row, res.out_col, res.value,
                                                         res.last);
  end

  // One request: optional idle gap, then hold valid until accepted.
  task automatic send(op_t op, logic [8:0] idx, logic [31:0] w);
    int gap;
    gap = 0;
    if (!calm) while ($urandom_range(99) < 34) gap++;
    if (gap > 0) begin
      cmd.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd.valid <= 1'b1;
    cmd.operation <= op;
    cmd.word_index <= idx;
    cmd.word <= w;
    do @(posedge clk); while (!cmd.ready);
    tile.take_request(op, idx, w);
  endtask

  task automatic drain();
    cmd.valid <= 1'b0;
    while (tile.owed.size() != 0) @(posedge clk);
  endtask

  // fp16 with a normal exponent, any sign
  function automatic logic [15:0] plain_half();
    return {1'($urandom), 5'($urandom_range(8, 20)), 10'($urandom)};
  endfunction

  function automatic logic [31:0] plain_single();
    return {1'($urandom), 8'($urandom_range(110, 140)), 23'($urandom)};
  endfunction

  // Weight word; fp16 column scale words mostly well-behaved, rarely anything at all.
  function automatic logic [31:0] weight_word(int idx);
    if (idx < 8 && $urandom_range(9) != 0) return {plain_half(), plain_half()};
    return $urandom;
  endfunction

  function automatic logic [31:0] act_word(int idx);
    if (idx < 4 && $urandom_range(9) != 0) return plain_single();
    return $urandom;
  endfunction

  // Fill both stores completely, so no accumulate reads an unloaded word.
  task automatic load_all(logic odd_scales);
    logic [15:0] odd_half[16] = '{16'h0001, 16'h03ff, 16'h7c00, 16'hfc00, 16'h7e01, 16'h8000,
                                 16'h3c00, 16'hfbff, 16'h0400, 16'h8001, 16'h7bff, 16'h0000,
                                 16'h3555, 16'hc000, 16'h7d00, 16'h7c00};
    logic [31:0] odd_single[4] = '{32'h3f80_0000, 32'h0000_0001, 32'h7f7f_ffff,
                                   32'h8000_0000};
    for (int i = 0; i < WGT_WORDS; i++) begin
      if (odd_scales && i < 8) send(OP_LOAD_WGT, 9'(i), {odd_half[2 * i + 1], odd_half[2 * i]});
      else if (odd_scales && i < 11) send(OP_LOAD_WGT, 9'(i), 32'hffff_ffff);
      else send(OP_LOAD_WGT, 9'(i), weight_word(i));
    end
    for (int i = 0; i < ACT_WORDS; i++) begin
      if (odd_scales && i < 4) send(OP_LOAD_ACT, 9'(i), odd_single[i]);
      else send(OP_LOAD_ACT, 9'(i), act_word(i));
    end
  endtask

  initial begin
    int r;
    int idx;
    tile = new();
    calm = 1'b0;
    hold_req = 0;
    rst <= 1'b1;
    cmd.valid <= 1'b0;
    cmd.operation <= OP_LOAD_WGT;
    cmd.word_index <= '0;
    cmd.word <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: emit of an empty tile, dropped out-of-range loads, then a
    // superblock whose scales are fp16 subnormals, infinities and NaNs.
    send(OP_EMIT, 9'd0, 32'd0);
    send(OP_LOAD_WGT, 9'd288, 32'hffff_ffff);
    send(OP_LOAD_WGT, 9'd511, 32'hffff_ffff);
    send(OP_LOAD_ACT, 9'd292, 32'hffff_ffff);
    send(OP_LOAD_ACT, 9'd511, 32'hffff_ffff);
    load_all(1'b1);
    send(OP_ACCUM, 9'd0, 32'd0);
    send(OP_ACCUM, 9'd0, 32'd0);

    // Long receiver hold-off while loads keep coming behind the emit.
    hold_req = 400;
    send(OP_EMIT, 9'd0, 32'd0);
    load_all(1'b0);
    drain();

    send(OP_ACCUM, 9'd0, 32'd0);
    send(OP_EMIT, 9'd0, 32'd0);

    // Random: reloads biased to the scale words, accumulates and emits.
    for (int n = 0; n < 110; n++) begin
      calm = (n >= 40 && n < 70);
      r = $urandom_range(99);
      if (n == 109 || r < 7) begin
        send(OP_EMIT, 9'd0, 32'd0);
      end else if (r < 17) begin
        send(OP_ACCUM, 9'($urandom), $urandom);
      end else if (r < 22) begin
        send(op_t'($urandom_range(1)), 9'($urandom_range(292, 511)), $urandom);
      end else if (r < 60) begin
        idx = $urandom_range(31);
        send(OP_LOAD_WGT, 9'(idx), weight_word(idx));
      end else if (r < 75) begin
        idx = $urandom_range(3);
        send(OP_LOAD_ACT, 9'(idx), act_word(idx));
      end else if (r < 88) begin
        idx = $urandom_range(WGT_WORDS - 1);
        send(OP_LOAD_WGT, 9'(idx), weight_word(idx));
      end else begin
        idx = $urandom_range(ACT_WORDS - 1);
        send(OP_LOAD_ACT, 9'(idx), act_word(idx));
      end
    end
    calm = 1'b0;
    drain();
    repeat (200) @(posedge clk);

    if (tile.mismatches == 0 && tile.owed.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/q4k_pkg.sv
src/q4k_cmd_if.sv
src/q4k_res_if.sv
src/q4k_ram.sv
src/q4k_q8k_tile_dot_product_core.sv
tb/q4k_q8k_tile_dot_product_core_test.sv
